@@ src/wsp_pkg.sv @@
// ----------------------------------------------------------------------------
// wsp_pkg: shared types and constants for the wheel speed PID
// Holds the step codes, the struct types between the controller and the
// datapath, a divide-step test and a Q16.8 saturation helper.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int NUM_WHEELS_DEF = 2;

    localparam int DIV_NUM_W = 60;
    localparam int DIV_DEN_W = 24;

    localparam logic [15:0] FILT_KEEP   = 16'd55968;
    localparam logic [12:0] FILT_NEW    = 13'd4771;
    localparam logic [19:0] US_PER_S    = 20'd1000000;
    localparam logic [19:0] US_HALF     = 20'd500000;
    localparam logic [27:0] CPS_SCALE   = 28'd256000000;
    localparam logic [23:0] Q8_POS_MAX  = 24'h7F_FFFF;
    localparam logic [23:0] Q8_NEG_MAG  = 24'h80_0000;
    localparam logic [47:0] WIDE_CLAMP  = 48'h7FFF_FFFF_FFFF;
    localparam logic [71:0] I_TERM_CAP  = 72'h1 << 62;
    localparam logic [71:0] D_TERM_CAP  = 72'h1 << 60;
    localparam logic [7:0]  PWM_MAX     = 8'd255;
    localparam logic [39:0] CLAMP_NUM   = 40'hFF_0000_0000;
    // ceil(2^65 / 15625): x / 1000000 = ((x >> 6) * RECIP_15625) >> 65
    // exact for (x >> 6) below 2^51
    localparam logic [51:0] RECIP_15625 = 52'd2361183241434823;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_GAIN_P_A   = 3'd0,
        REG_GAIN_I_A   = 3'd1,
        REG_GAIN_D_A   = 3'd2,
        REG_GAIN_P_B   = 3'd3,
        REG_GAIN_I_B   = 3'd4,
        REG_GAIN_D_B   = 3'd5,
        REG_COUNT_RPM  = 3'd6,
        REG_REVERSE    = 3'd7
    } reg_idx_t;

    typedef enum logic [4:0] {
        OP_DELTA    = 5'd0,
        OP_CPS_MUL  = 5'd1,
        OP_CPS_DIV  = 5'd2,
        OP_RAW_HI   = 5'd3,
        OP_RAW_LO   = 5'd4,
        OP_RAW_SAT  = 5'd5,
        OP_FILT_OLD = 5'd6,
        OP_FILT_NEW = 5'd7,
        OP_FILT_SUM = 5'd8,
        OP_ERR      = 5'd9,
        OP_INT_MUL  = 5'd10,
        OP_INT_R0   = 5'd11,
        OP_INT_R1   = 5'd12,
        OP_INT_R2   = 5'd13,
        OP_INT_R3   = 5'd14,
        OP_INT_ADD  = 5'd15,
        OP_LIM_DIV  = 5'd16,
        OP_CLAMP    = 5'd17,
        OP_DER_MUL  = 5'd18,
        OP_DER_DIV  = 5'd19,
        OP_P_MUL    = 5'd20,
        OP_I_LO     = 5'd21,
        OP_I_HI     = 5'd22,
        OP_I_SUM    = 5'd23,
        OP_D_LO     = 5'd24,
        OP_D_HI     = 5'd25,
        OP_D_SUM    = 5'd26,
        OP_FINISH   = 5'd27
    } op_t;

    typedef struct packed {
        logic [23:0] gain_p_a;
        logic [23:0] gain_i_a;
        logic [23:0] gain_d_a;
        logic [23:0] gain_p_b;
        logic [23:0] gain_i_b;
        logic [23:0] gain_d_b;
        logic [31:0] count_to_rpm;
        logic [1:0]  reverse_bits;
    } cfg_t;

    typedef struct packed {
        logic        wheel;
        logic [31:0] encoder_count;
        logic [23:0] elapsed_us;
        logic [23:0] target_rpm;
        logic        clear_integral;
    } in_t;

    typedef struct packed {
        logic        wheel_out;
        logic        reverse_dir;
        logic [7:0]  pwm_duty;
        logic [23:0] filtered_rpm;
    } res_t;

    typedef struct packed {
        logic load;
        logic step;
        op_t  op;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

    function automatic logic is_div_op(input op_t op);
        is_div_op = (op == OP_CPS_DIV) || (op == OP_LIM_DIV) || (op == OP_DER_DIV);
    endfunction

    // Saturate a magnitude with sign to signed Q16.8
    function automatic logic [23:0] sat24(input logic [63:0] m, input logic neg);
        logic [63:0] lim;
        lim = neg ? 64'(Q8_NEG_MAG) : 64'(Q8_POS_MAX);
        if (m > lim) begin
            sat24 = neg ? Q8_NEG_MAG : Q8_POS_MAX;
        end else begin
            sat24 = neg ? 24'(64'd0 - m) : m[23:0];
        end
    endfunction

endpackage

@@ src/wsp_div.sv @@
// ----------------------------------------------------------------------------
// wsp_div: restoring divider
// One quotient bit per cycle, unsigned numerator over unsigned denominator.
// ----------------------------------------------------------------------------
module wsp_div import wsp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DIV_NUM_W-1]};
        ge      = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

@@ src/wsp_datapath.sv @@
// ----------------------------------------------------------------------------
// wsp_datapath: per-wheel state and fixed-point arithmetic
// Executes one step code per command; divides go to the shared divider.
// ----------------------------------------------------------------------------
module wsp_datapath import wsp_pkg::*; #(
    parameter int NUM_WHEELS = NUM_WHEELS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  in_t   in_item,
    input  cfg_t  cfg,
    input  cmd_t  cmd,
    output stat_t stat,
    output res_t  res
);

    localparam int SLOT_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

    // per-slot state
    logic [31:0]        last_cnt_reg [NUM_WHEELS];
    logic signed [23:0] filt_st_reg  [NUM_WHEELS];
    logic signed [23:0] raw_st_reg   [NUM_WHEELS];
    logic signed [47:0] integ_st_reg [NUM_WHEELS];
    logic signed [24:0] perr_st_reg  [NUM_WHEELS];

    // latched item
    logic               wheel_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [31:0]        cnt_reg;
    logic [23:0]        el_reg;
    logic [23:0]        tgt_reg;
    logic               clr_reg;

    // working registers
    logic [31:0]        dmag_reg;
    logic               dneg_reg;
    logic [59:0]        num_reg;
    logic [59:0]        rhi_reg;
    logic [63:0]        rlo_reg;
    logic [23:0]        raw_reg;
    logic signed [40:0] fa_reg;
    logic signed [40:0] fb_reg;
    logic [23:0]        filt_reg;
    logic [24:0]        e_reg;
    logic [24:0]        emag_reg;
    logic               qneg_reg;
    logic [103:0]       racc_reg;
    logic [49:0]        integ_reg;
    logic [47:0]        icl_reg;
    logic [47:0]        imag_reg;
    logic               ineg_reg;
    logic [48:0]        pterm_reg;
    logic [47:0]        mlo_reg;
    logic [47:0]        mhi_reg;
    logic [54:0]        iterm_reg;
    logic [60:0]        dterm_reg;
    res_t               res_reg;

    // divider hookup
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] q;

    wsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (q)
    );

    assign stat.div_done = div_done;

    logic [23:0] kp, ki, kd;
    logic [SLOT_W-1:0] slot_in;

    // combinational step results
    logic [31:0]        d_diff, d_mag;
    logic [48:0]        raw_r, raw_m;
    logic [24:0]        fsum;
    logic signed [40:0] fa_c, fb_c, acc;
    logic [40:0]        acc_mag, rnd;
    logic [24:0]        e_c;
    logic [48:0]        ep;
    logic [25:0]        rp_a, rp_b;
    logic [51:0]        rprod;
    logic [49:0]        qs50, base50;
    logic [47:0]        lim48;
    logic [49:0]        lim50, nlim50, cl50;
    logic [25:0]        diff26, dm26;
    logic [45:0]        dprod;
    logic [71:0]        full72;
    logic [63:0]        sp, si, sd, u, umag;

    always_comb begin
        slot_in = (NUM_WHEELS > 1) ? SLOT_W'(in_item.wheel) : '0;
        kp = wheel_reg ? cfg.gain_p_b : cfg.gain_p_a;
        ki = wheel_reg ? cfg.gain_i_b : cfg.gain_i_a;
        kd = wheel_reg ? cfg.gain_d_b : cfg.gain_d_a;

        d_diff = cnt_reg - last_cnt_reg[slot_reg];
        d_mag  = d_diff[31] ? (32'd0 - d_diff) : d_diff;

        raw_r = (49'(rhi_reg[7:0]) << 16) + 49'(rlo_reg[63:16]);
        raw_m = (rhi_reg >= 60'd256) ? 49'(Q8_NEG_MAG) : raw_r;

        fa_c = $signed({{17{filt_st_reg[slot_reg][23]}}, filt_st_reg[slot_reg]})
             * $signed(41'(FILT_KEEP));
        fsum = {raw_reg[23], raw_reg}
             + {raw_st_reg[slot_reg][23], raw_st_reg[slot_reg]};
        fb_c = $signed({{16{fsum[24]}}, fsum}) * $signed(41'(FILT_NEW));
        acc     = fa_reg + fb_reg;
        acc_mag = acc[40] ? (41'd0 - 41'(acc)) : 41'(acc);
        rnd     = (acc_mag + 41'd32768) >> 16;

        e_c = {tgt_reg[23], tgt_reg} - {filt_reg[23], filt_reg};
        ep  = 49'(emag_reg) * 49'(el_reg);

        rprod = 52'(rp_a) * 52'(rp_b);

        qs50   = qneg_reg ? (50'd0 - 50'(racc_reg[103:65])) : 50'(racc_reg[103:65]);
        base50 = clr_reg ? 50'd0 : {{2{integ_st_reg[slot_reg][47]}}, integ_st_reg[slot_reg]};

        lim48  = (cfg.gain_i_a != 24'd0) ? 48'(q[40:0]) : WIDE_CLAMP;
        lim50  = {2'b00, lim48};
        nlim50 = 50'd0 - lim50;
        if ($signed(integ_reg) > $signed(lim50)) begin
            cl50 = lim50;
        end else if ($signed(integ_reg) < $signed(nlim50)) begin
            cl50 = nlim50;
        end else begin
            cl50 = integ_reg;
        end

        diff26 = {e_reg[24], e_reg} - {perr_st_reg[slot_reg][24], perr_st_reg[slot_reg]};
        dm26   = diff26[25] ? (26'd0 - diff26) : diff26;
        dprod  = 46'(dm26) * 46'(US_PER_S);

        if (cmd.op == OP_I_SUM || cmd.op == OP_D_SUM) begin
            full72 = 72'(mlo_reg) + (72'(mhi_reg) << 24);
        end else begin
            full72 = '0;
        end

        sp   = e_reg[24] ? (64'd0 - 64'(pterm_reg)) : 64'(pterm_reg);
        si   = ineg_reg  ? (64'd0 - 64'(iterm_reg)) : 64'(iterm_reg);
        sd   = qneg_reg  ? (64'd0 - 64'(dterm_reg)) : 64'(dterm_reg);
        u    = sp + si + sd;
        umag = u[63] ? (64'd0 - u) : u;

        div_start = cmd.step && is_div_op(cmd.op);
        div_num   = num_reg;
        div_den   = el_reg;
        rp_a      = '0;
        rp_b      = '0;
        // integral step over one million: (num >> 6) times the reciprocal,
        // four partial products of the 51-bit operand and the 52-bit constant
        case (cmd.op)
            OP_INT_R0: begin
                rp_a = num_reg[31:6];
                rp_b = RECIP_15625[25:0];
            end
            OP_INT_R1: begin
                rp_a = num_reg[31:6];
                rp_b = RECIP_15625[51:26];
            end
            OP_INT_R2: begin
                rp_a = {1'b0, num_reg[56:32]};
                rp_b = RECIP_15625[25:0];
            end
            OP_INT_R3: begin
                rp_a = {1'b0, num_reg[56:32]};
                rp_b = RECIP_15625[51:26];
            end
            OP_LIM_DIV: begin
                div_num = 60'(CLAMP_NUM);
                div_den = cfg.gain_i_a;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                last_cnt_reg[i] <= '0;
                filt_st_reg[i]  <= '0;
                raw_st_reg[i]   <= '0;
                integ_st_reg[i] <= '0;
                perr_st_reg[i]  <= '0;
            end
        end else if (cmd.step && cmd.op == OP_FINISH) begin
            last_cnt_reg[slot_reg] <= cnt_reg;
            filt_st_reg[slot_reg]  <= filt_reg;
            raw_st_reg[slot_reg]   <= raw_reg;
            integ_st_reg[slot_reg] <= icl_reg;
            perr_st_reg[slot_reg]  <= e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            wheel_reg <= in_item.wheel;
            slot_reg  <= slot_in;
            cnt_reg   <= in_item.encoder_count;
            // zero elapsed time counts as one microsecond
            el_reg    <= (in_item.elapsed_us == 24'd0) ? 24'd1 : in_item.elapsed_us;
            tgt_reg   <= in_item.target_rpm;
            clr_reg   <= in_item.clear_integral;
        end
        if (cmd.step) begin
            case (cmd.op)
                OP_DELTA: begin
                    dmag_reg <= d_mag;
                    dneg_reg <= d_diff[31];
                end
                OP_CPS_MUL:  num_reg <= 60'(dmag_reg) * 60'(CPS_SCALE);
                OP_RAW_HI:   rhi_reg <= 60'(q[59:32]) * 60'(cfg.count_to_rpm);
                OP_RAW_LO:   rlo_reg <= 64'(q[31:0]) * 64'(cfg.count_to_rpm);
                OP_RAW_SAT:  raw_reg <= sat24(64'(raw_m), dneg_reg);
                OP_FILT_OLD: fa_reg  <= fa_c;
                OP_FILT_NEW: fb_reg  <= fb_c;
                OP_FILT_SUM: filt_reg <= sat24(64'(rnd), acc[40]);
                OP_ERR: begin
                    e_reg    <= e_c;
                    emag_reg <= e_c[24] ? (25'd0 - e_c) : e_c;
                end
                OP_INT_MUL: begin
                    num_reg  <= 60'({ep, 8'h00}) + 60'(US_HALF);
                    qneg_reg <= e_reg[24];
                end
                OP_INT_R0:  racc_reg <= 104'(rprod);
                OP_INT_R1:  racc_reg <= racc_reg + (104'(rprod) << 26);
                OP_INT_R2:  racc_reg <= racc_reg + (104'(rprod) << 26);
                OP_INT_R3:  racc_reg <= racc_reg + (104'(rprod) << 52);
                OP_INT_ADD: integ_reg <= base50 + qs50;
                OP_CLAMP: begin
                    icl_reg  <= cl50[47:0];
                    imag_reg <= cl50[49] ? 48'(50'd0 - cl50) : cl50[47:0];
                    ineg_reg <= cl50[49];
                end
                OP_DER_MUL: begin
                    num_reg  <= 60'(dprod) + 60'(el_reg[23:1]);
                    qneg_reg <= diff26[25];
                end
                OP_P_MUL: pterm_reg <= 49'(kp) * 49'(emag_reg);
                OP_I_LO:  mlo_reg <= 48'(ki) * 48'(imag_reg[23:0]);
                OP_I_HI:  mhi_reg <= 48'(ki) * 48'(imag_reg[47:24]);
                OP_I_SUM: iterm_reg <= 55'(((full72 > I_TERM_CAP) ? I_TERM_CAP : full72) >> 8);
                OP_D_LO:  mlo_reg <= 48'(kd) * 48'(q[23:0]);
                OP_D_HI:  mhi_reg <= 48'(kd) * 48'(q[47:24]);
                OP_D_SUM: dterm_reg <= 61'((full72 > D_TERM_CAP) ? D_TERM_CAP : full72);
                OP_FINISH: begin
                    res_reg.wheel_out    <= wheel_reg;
                    res_reg.reverse_dir  <= u[63] ^ cfg.reverse_bits[wheel_reg];
                    res_reg.pwm_duty     <= (umag[63:24] > 40'(PWM_MAX)) ? PWM_MAX
                                                                          : umag[31:24];
                    res_reg.filtered_rpm <= filt_reg;
                end
                default: ;
            endcase
        end
    end

    assign res = res_reg;

endmodule

@@ src/wsp_ctrl.sv @@
// ----------------------------------------------------------------------------
// wsp_ctrl: sequencer for the wheel speed PID
// Walks the step codes, waits on the divider, hands the result out.
// ----------------------------------------------------------------------------
module wsp_ctrl import wsp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  out_free,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_DIVW = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.op     = op_reg;
        cmd.emit   = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    op_next    = OP_DELTA;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                if (is_div_op(op_reg)) begin
                    state_next = ST_DIVW;
                end else if (op_reg == OP_FINISH) begin
                    state_next = ST_EMIT;
                end else begin
                    op_next = op_t'(op_reg + 5'd1);
                end
            end
            ST_DIVW: begin
                if (stat.div_done) begin
                    op_next    = op_t'(op_reg + 5'd1);
                    state_next = ST_RUN;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_DELTA;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

@@ src/wheel_speed_pid.sv @@
// ----------------------------------------------------------------------------
// wheel_speed_pid: closed-loop speed controller for the drive wheels
// One control tick per transaction: raw speed from the encoder delta,
// low-pass filter, PID with clamped integral, PWM duty and direction.
//
//  channel | dir | handshake        | content
//  --------+-----+------------------+-----------------------------------------
//  s_      | in  | s_tvalid/tready  | tuser: wheel; tdata: tick fields
//  m_      | out | m_tvalid/tready  | tuser: wheel_out; tdata: drive result
//  cfg_    | in  | cfg_we           | gains, count scale, reversal bits
//
// A tick runs from accept through the load, the 28 step codes and, once the
// output is free, the hand-off; only then is the next tick accepted. Three
// divides in the shared divider (speed, integral clamp, derivative) hold the
// sequencer until the divider is done; the integral step divides by one
// million as a four-step reciprocal multiply.
// Reset is synchronous, active low; it clears all per-wheel state, the
// gains, the reversal bits, and sets count_to_rpm to 1.0.
// A stalled output holds its transaction; the next tick is taken meanwhile,
// and its result waits until the output register is free.
// ----------------------------------------------------------------------------
module wheel_speed_pid import wsp_pkg::*; #(
    parameter int NUM_WHEELS = NUM_WHEELS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,   // [0] wheel
    // [31:0] encoder_count, [55:32] elapsed_us, [79:56] target_rpm,
    // [80] clear_integral, [87:81] zero
    input  logic [87:0]           s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_tuser,   // [0] wheel_out
    // [0] reverse_dir, [8:1] pwm_duty, [32:9] filtered_rpm, [39:33] zero
    output logic [39:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t  cfg_reg;
    in_t   in_item;
    cmd_t  cmd;
    stat_t stat;
    res_t  res;

    logic        m_tvalid_reg;
    logic        m_tuser_reg;
    logic [39:0] m_tdata_reg;
    logic        out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg              <= '0;
            cfg_reg.count_to_rpm <= 32'h0001_0000;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_addr))
                REG_GAIN_P_A:  cfg_reg.gain_p_a     <= cfg_wdata[23:0];
                REG_GAIN_I_A:  cfg_reg.gain_i_a     <= cfg_wdata[23:0];
                REG_GAIN_D_A:  cfg_reg.gain_d_a     <= cfg_wdata[23:0];
                REG_GAIN_P_B:  cfg_reg.gain_p_b     <= cfg_wdata[23:0];
                REG_GAIN_I_B:  cfg_reg.gain_i_b     <= cfg_wdata[23:0];
                REG_GAIN_D_B:  cfg_reg.gain_d_b     <= cfg_wdata[23:0];
                REG_COUNT_RPM: cfg_reg.count_to_rpm <= cfg_wdata;
                REG_REVERSE:   cfg_reg.reverse_bits <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // unpack the input transaction
    always_comb begin
        in_item.wheel          = s_tuser;
        in_item.encoder_count  = s_tdata[31:0];
        in_item.elapsed_us     = s_tdata[55:32];
        in_item.target_rpm     = s_tdata[79:56];
        in_item.clear_integral = s_tdata[80];
    end

    assign out_free = !m_tvalid_reg || m_tready;

    wsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd)
    );

    wsp_datapath #(
        .NUM_WHEELS (NUM_WHEELS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_item (in_item),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .stat    (stat),
        .res     (res)
    );

    // output register: load on emit, drop on downstream accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tuser_reg <= res.wheel_out;
            m_tdata_reg <= {7'd0, res.filtered_rpm, res.pwm_duty, res.reverse_dir};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    // a result is never written over one that is still waiting
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result loaded over a pending transaction");

    // one tick at a time: no second accept right after one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a tick is in progress");

    // a new result only appears from an emit
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(cmd.emit))
        else $error("output valid without emit");

endmodule

@@ tb/wsp_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wsp_checker: result predictor and scoreboard for wheel_speed_pid
// Mirrors the register writes and the accepted ticks, computes the expected
// drive result per tick and compares every result transaction in order.
// ----------------------------------------------------------------------------
module wsp_checker import wsp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  s_tuser,
    input  logic [87:0]           s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  m_tuser,
    input  logic [39:0]           m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    cfg_t            regs;
    logic [31:0]     last_cnt [2];
    longint          filt_spd [2];
    longint          prev_raw [2];
    longint          integ_acc [2];
    longint          prev_err [2];
    res_t            drive_q [$];

    assign pending = drive_q.size();

    function automatic longint rdiv(input longint num, input longint den);
        longint m;
        m = (num < 0) ? -num : num;
        m = (m + den / 2) / den;
        return (num < 0) ? -m : m;
    endfunction

    function automatic longint sat_q8(input longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // saturating unsigned product, both operands below 2^63
    function automatic logic [63:0] mul_cap(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] cap);
        logic [127:0] p;
        p = a * b;
        return (p > cap) ? cap : p[63:0];
    endfunction

    task automatic predict_tick(input logic w, input logic [87:0] d);
        logic [31:0]  cnt;
        longint       el, tgt, delta, raw, acc, f, e, integ, lim, deriv;
        logic [63:0]  dm, cps, kp, ki, kd, pt, it, dt, um, duty;
        logic [127:0] rm;
        logic         back;
        res_t         r;
        cnt = d[31:0];
        el  = d[55:32];
        tgt = longint'($signed(d[79:56]));
        if (el == 0) el = 1;
        kp = w ? regs.gain_p_b : regs.gain_p_a;
        ki = w ? regs.gain_i_b : regs.gain_i_a;
        kd = w ? regs.gain_d_b : regs.gain_d_a;
        delta = longint'($signed(cnt - last_cnt[w]));
        last_cnt[w] = cnt;
        dm  = (delta < 0) ? -delta : delta;
        cps = dm * 64'd256000000 / el;
        rm  = (128'(cps) * regs.count_to_rpm) >> 16;
        raw = (rm > 128'd8388608) ? 8388608 : longint'(rm);
        raw = sat_q8((delta < 0) ? -raw : raw);
        acc = 55968 * filt_spd[w] + 4771 * (raw + prev_raw[w]);
        f = (acc < 0) ? -((-acc + 32768) >>> 16) : ((acc + 32768) >>> 16);
        f = sat_q8(f);
        filt_spd[w] = f;
        prev_raw[w] = raw;
        e = tgt - f;
        integ = d[80] ? 0 : integ_acc[w];
        integ += rdiv(e * el * 256, 1000000);
        lim = (regs.gain_i_a != 0) ? ((64'd255 << 32) / regs.gain_i_a)
                                   : 64'h7FFF_FFFF_FFFF;
        if (integ > lim) integ = lim;
        if (integ < -lim) integ = -lim;
        integ_acc[w] = integ;
        deriv = rdiv((e - prev_err[w]) * 1000000, el);
        prev_err[w] = e;
        pt = kp * ((e < 0) ? -e : e);
        it = mul_cap(ki, (integ < 0) ? -integ : integ, 64'h1 << 62) >> 8;
        dt = mul_cap(kd, (deriv < 0) ? -deriv : deriv, 64'h1 << 60);
        um = ((e < 0) ? -pt : pt) + ((integ < 0) ? -it : it) + ((deriv < 0) ? -dt : dt);
        duty = $signed(um) < 0 ? (-um) >> 24 : um >> 24;
        if (duty > 255) duty = 255;
        back = ($signed(um) < 0) ^ regs.reverse_bits[w];
        r.wheel_out    = w;
        r.reverse_dir  = back;
        r.pwm_duty     = duty[7:0];
        r.filtered_rpm = f[23:0];
        drive_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs <= '{count_to_rpm: 32'd65536, default: '0};
            for (int i = 0; i < 2; i++) begin
                last_cnt[i] = '0; filt_spd[i] = 0; prev_raw[i] = 0;
                integ_acc[i] = 0; prev_err[i] = 0;
            end
            drive_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (reg_idx_t'(cfg_addr))
                    REG_GAIN_P_A:  regs.gain_p_a     <= cfg_wdata[23:0];
                    REG_GAIN_I_A:  regs.gain_i_a     <= cfg_wdata[23:0];
                    REG_GAIN_D_A:  regs.gain_d_a     <= cfg_wdata[23:0];
                    REG_GAIN_P_B:  regs.gain_p_b     <= cfg_wdata[23:0];
                    REG_GAIN_I_B:  regs.gain_i_b     <= cfg_wdata[23:0];
                    REG_GAIN_D_B:  regs.gain_d_b     <= cfg_wdata[23:0];
                    REG_COUNT_RPM: regs.count_to_rpm <= cfg_wdata;
                    REG_REVERSE:   regs.reverse_bits <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_tick(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (drive_q.size() == 0) begin
                    $error("unexpected result transaction: wheel %0d", m_tuser);
                    fail_count++;
                end else begin
                    res_t x;
                    x = drive_q.pop_front();
                    if (m_tuser !== x.wheel_out) begin
                        $error("wheel_out exp %0d got %0d", x.wheel_out, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[0] !== x.reverse_dir) begin
                        $error("reverse_dir exp %0d got %0d", x.reverse_dir, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[8:1] !== x.pwm_duty) begin
                        $error("pwm_duty exp %0d got %0d", x.pwm_duty, m_tdata[8:1]);
                        fail_count++;
                    end
                    if (m_tdata[32:9] !== x.filtered_rpm) begin
                        $error("filtered_rpm exp %0d got %0d", $signed(x.filtered_rpm),
                               $signed(m_tdata[32:9]));
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for wheel_speed_pid
// Drives directed and random control ticks through several gain settings
// with random idling on both channels; the checker scores every result.
// ----------------------------------------------------------------------------
module tb;
    import wsp_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic                  s_tuser = 1'b0;
    logic [87:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  m_tuser;
    logic [39:0]           m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    fail_count;
    int                    pending;
    bit                    hold_sink = 1'b0;   // long receiver hold-off request
    bit                    sink_busy = 1'b0;

    // per-wheel encoder positions for realistic ticks
    logic [31:0] enc_pos [2] = '{32'd0, 32'd0};

    always #6 aclk = ~aclk;

    wheel_speed_pid uut (.*);

    wsp_checker chk (.*);

    // Write one register at a clock edge.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one tick and hold it until the transaction completes; valid stays
    // high after the accept until the next gap, the next tick or a drain.
    task automatic send_tick(input logic w, input logic [31:0] cnt, input logic [23:0] el,
                             input logic [23:0] tgt, input logic clr);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w;
        s_tdata  <= {7'd0, clr, tgt, el, cnt};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Realistic tick: advance the wheel's encoder by a random amount.
    task automatic drive_tick(input logic w);
        logic [31:0] step;
        case ($urandom_range(0, 9))
            0:       step = $urandom();
            1, 2:    step = 32'($signed($urandom_range(0, 200)) - 100);
            default: step = 32'($signed($urandom_range(0, 4000)) - 2000);
        endcase
        enc_pos[w] += step;
        send_tick(w, enc_pos[w], ($urandom_range(0, 7) == 0) ? 24'($urandom())
                  : 24'($urandom_range(1000, 20000)),
                  ($urandom_range(0, 5) == 0) ? 24'($urandom())
                  : 24'($signed($urandom_range(0, 40000)) - 20000),
                  $urandom_range(0, 7) == 0);
    endtask

    // Drop the input and let everything drain so registers change only while
    // the block is idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic load_gains(input logic [23:0] g [6], input logic [31:0] scale,
                              input logic [1:0] rev);
        write_reg(REG_GAIN_P_A, {8'd0, g[0]});
        write_reg(REG_GAIN_I_A, {8'd0, g[1]});
        write_reg(REG_GAIN_D_A, {8'd0, g[2]});
        write_reg(REG_GAIN_P_B, {8'd0, g[3]});
        write_reg(REG_GAIN_I_B, {8'd0, g[4]});
        write_reg(REG_GAIN_D_B, {8'd0, g[5]});
        write_reg(REG_COUNT_RPM, scale);
        write_reg(REG_REVERSE, {30'd0, rev});
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn || hold_sink) begin
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            m_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ~m_tready;
        end else begin
            m_tready <= ($urandom_range(0, 9) != 0);
        end
    end

    initial begin
        logic [23:0] g [6];
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset settings, first ticks, extremes, zero elapsed time.
        send_tick(1'b0, 32'd1000, 24'd10000, 24'd5000, 1'b0);
        send_tick(1'b1, 32'h8000_0000, 24'd1, 24'h7F_FFFF, 1'b0);
        drain();
        g = '{24'h01_0000, 24'h00_8000, 24'h00_0100, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF};
        load_gains(g, 32'hFFFF_FFFF, 2'b01);
        send_tick(1'b0, 32'h7FFF_FFFF, 24'd0, 24'h80_0000, 1'b1);
        send_tick(1'b0, 32'h8000_0000, 24'hFF_FFFF, 24'h7F_FFFF, 1'b0);
        send_tick(1'b1, 32'hFFFF_FFFF, 24'd0, 24'h00_0000, 1'b1);
        send_tick(1'b1, 32'd0, 24'd1, 24'h80_0000, 1'b0);
        send_tick(1'b0, 32'd0, 24'd5, 24'h00_0000, 1'b0);
        send_tick(1'b1, 32'd5, 24'd10000, 24'h00_0000, 1'b0);
        send_tick(1'b1, 32'd5, 24'd10000, 24'h00_0000, 1'b1);
        drain();
        // Zero integral gain A gives the widest clamp.
        g = '{24'd0, 24'd0, 24'd0, 24'h00_1000, 24'h00_0040, 24'h00_0000};
        load_gains(g, 32'd0, 2'b10);
        for (int i = 0; i < 8; i++) send_tick(i[0], 32'(i * 12345), 24'd20000,
                                              24'h7F_FFFF, 1'b0);
        drain();
        enc_pos = '{32'd0, 32'd0};
        send_tick(1'b0, 32'd0, 24'd1, 24'd0, 1'b1);
        send_tick(1'b1, 32'd0, 24'd1, 24'd0, 1'b1);

        // Random phases with fresh settings, one of them with the sink held off.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            for (int k = 0; k < 6; k++) begin
                case ($urandom_range(0, 3))
                    0:       g[k] = 24'd0;
                    1:       g[k] = 24'hFF_FFFF;
                    default: g[k] = 24'($urandom_range(0, 24'h04_0000));
                endcase
            end
            load_gains(g, (ph == 0) ? 32'd65536 : (ph == 1) ? 32'hFFFF_FFFF
                       : $urandom_range(0, 32'h0010_0000), 2'(ph));
            if (ph == 3) begin
                fork
                    begin
                        hold_sink = 1'b1;
                        repeat (3000) @(posedge aclk);
                        hold_sink = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 160; n++) drive_tick($urandom_range(0, 1));
        end

        drain();
        if (fail_count == 0) begin
            $display("wheel_speed_pid regression: pass");
        end else begin
            $display("wheel_speed_pid regression: fail");
        end
        $finish;
    end

    // Hard limit on run time.
    initial begin
        #200ms;
        $display("wheel_speed_pid regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
src/wsp_pkg.sv
src/wsp_div.sv
src/wsp_datapath.sv
src/wsp_ctrl.sv
src/wheel_speed_pid.sv
tb/wsp_checker.sv
tb/tb.sv
